// File: hw/rtl/qs_pkg.sv
package qs_pkg;

    localparam int CW_DEF      = 16;
    localparam int NI_DEF      = 16;

    // Q30 angles and weights
    localparam int Q           = 30;
    localparam longint ONE_Q30 = 64'sd1 <<< Q;
    localparam int T_W         = 17;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;
    localparam int THR_W       = 15;
    localparam logic [THR_W-1:0] THR_RESET = 15'd164;

    localparam int DOT_W       = 36;
    localparam int AD_W        = 31;
    localparam int REM_W       = 62;
    localparam int SQRT_STEPS  = 31;
    localparam int ANG_W       = 34;
    localparam int RW          = 33;
    localparam int DIV_STEPS   = 30;
    localparam int DIV_LAT     = DIV_STEPS + 1;
    localparam int WT_W        = 32;

    // side word: {a_w..a_z, b_w..b_z, t, flip, neg, lin, ad}
    localparam int SIDE_FIX_W  = T_W + 3 + AD_W;
    localparam int OFS_LIN     = AD_W;
    localparam int OFS_NEG     = AD_W + 1;
    localparam int OFS_FLIP    = AD_W + 2;
    localparam int OFS_T       = AD_W + 3;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        case (idx)
            0:  return ANG_W'(843314856);
            1:  return ANG_W'(497837829);
            2:  return ANG_W'(263043836);
            3:  return ANG_W'(133525158);
            4:  return ANG_W'(67021686);
            5:  return ANG_W'(33543515);
            6:  return ANG_W'(16775850);
            7:  return ANG_W'(8388437);
            8:  return ANG_W'(4194282);
            9:  return ANG_W'(2097149);
            10: return ANG_W'(1048575);
            11: return ANG_W'(524287);
            12: return ANG_W'(262143);
            13: return ANG_W'(131071);
            14: return ANG_W'(65535);
            15: return ANG_W'(32767);
            16: return ANG_W'(16383);
            17: return ANG_W'(8191);
            18: return ANG_W'(4095);
            19: return ANG_W'(2047);
            20: return ANG_W'(1023);
            21: return ANG_W'(511);
            22: return ANG_W'(255);
            23: return ANG_W'(127);
            24: return ANG_W'(63);
            25: return ANG_W'(31);
            26: return ANG_W'(15);
            27: return ANG_W'(7);
            28: return ANG_W'(3);
            29: return ANG_W'(1);
            default: return '0;
        endcase
    endfunction

endpackage

// File: hw/rtl/qs_in_if.sv
interface qs_in_if import qs_pkg::*; #(parameter int CW = CW_DEF) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic [T_W-1:0]       fraction;
    logic                 allow_flip;

    modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, fraction,
                    allow_flip, input ready);
    modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, fraction,
                    allow_flip, output ready);
endinterface

// File: hw/rtl/qs_out_if.sv
interface qs_out_if import qs_pkg::*; #(parameter int CW = CW_DEF) ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] r_w;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;

    modport source (output valid, r_w, r_x, r_y, r_z, input ready);
    modport sink   (input valid, r_w, r_x, r_y, r_z, output ready);
endinterface

// File: hw/rtl/quaternion_slerp_top.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    a_w..a_z, b_w..b_z (Q2.14), fraction (Q1.16), allow_flip
// o_out     out  valid/ready    r_w..r_z (Q2.14, saturated)
// cfg       in   APB write/read linear_threshold at byte address 0
//
// One item per cycle while the skid is empty; each item passes the 31-step square
// root, the vectoring and rotation CORDIC chains and the 31-stage quotient pipeline.
// Reset is synchronous, active low; it clears valid bits and loads the threshold to 164.
// A one-entry skid behind the output register takes a result when the sink stalls; the
// whole pipe holds while the skid is full, so no item is lost or repeated.
module quaternion_slerp_top import qs_pkg::*; #(
    parameter int COMPONENT_WIDTH   = CW_DEF,
    parameter int CORDIC_ITERATIONS = NI_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qs_in_if.sink       i_in,
    qs_out_if.source    o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW     = COMPONENT_WIDTH;
    localparam int NI     = CORDIC_ITERATIONS;
    localparam int SIDE_W = 8 * CW + SIDE_FIX_W;
    localparam logic REG_LINEAR_THRESHOLD = 1'b0;

    logic [THR_W-1:0] r_thr;
    logic             r_out_valid, r_skid_valid;
    logic signed [CW-1:0] r_out_r  [4];
    logic signed [CW-1:0] r_skid_r [4];
    logic             r_ang_valid;
    logic [AD_W-1:0]  r_theta, r_ang1, r_ang2;
    logic [SIDE_W-1:0] r_side2;

    logic             w_en, w_cfg_wr;
    logic signed [CW-1:0] w_in_a [4];
    logic signed [CW-1:0] w_in_b [4];
    logic             w_fr_valid, w_sq_valid, w_vec_valid, w_den_valid, w_num1_valid;
    logic             w_num2_valid, w_div1_valid, w_div2_valid, w_comb_valid;
    logic             w_den_pos, w_unused_pos;
    logic [REM_W-1:0] w_rem;
    logic [AD_W-1:0]  w_root, w_q1, w_q2, w_theta;
    logic [SIDE_W-1:0] w_side0, w_side1, w_side2, w_side3;
    logic signed [ANG_W-1:0] w_vec_z, w_den, w_num1, w_num2;
    logic signed [ANG_W-1:0] w_vx, w_vy, w_d_x, w_d_z, w_n1_x, w_n1_z, w_n2_x, w_n2_z;
    logic [T_W-1:0]   w_t2;
    logic [AD_W+T_W-1:0] n_m1, n_m2;
    logic signed [CW-1:0] w_comb_r [4];

    // the whole pipe advances unless the skid holds a result
    assign w_en       = !r_skid_valid;
    assign i_in.ready = w_en;

    assign w_in_a[0] = i_in.a_w;
    assign w_in_a[1] = i_in.a_x;
    assign w_in_a[2] = i_in.a_y;
    assign w_in_a[3] = i_in.a_z;
    assign w_in_b[0] = i_in.b_w;
    assign w_in_b[1] = i_in.b_x;
    assign w_in_b[2] = i_in.b_y;
    assign w_in_b[3] = i_in.b_z;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_LINEAR_THRESHOLD) ? 32'(r_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (w_cfg_wr && paddr[2] == REG_LINEAR_THRESHOLD) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    qs_front #(.CW(CW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in.valid),
        .i_a        (w_in_a),
        .i_b        (w_in_b),
        .i_fraction (i_in.fraction),
        .i_flip     (i_in.allow_flip),
        .i_thr      (r_thr),
        .o_valid    (w_fr_valid),
        .o_rem      (w_rem),
        .o_side     (w_side0)
    );

    qs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_rem   (w_rem),
        .o_valid (w_sq_valid),
        .o_root  (w_root)
    );

    qs_delay #(.W(SIDE_W), .DEPTH(SQRT_STEPS)) u_dly_sqrt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_side0),
        .o_d   (w_side1)
    );

    // acos(|d|) = atan2(sqrt(1 - d*d), |d|)
    qs_cordic #(.NI(NI), .VECTOR(1'b1)) u_acos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_x     (ANG_W'(w_side1[AD_W-1:0])),
        .i_y     (ANG_W'(w_root)),
        .i_z     ('0),
        .o_valid (w_vec_valid),
        .o_x     (w_vx),
        .o_y     (w_vy),
        .o_z     (w_vec_z)
    );

    qs_delay #(.W(SIDE_W), .DEPTH(NI)) u_dly_acos (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_side1),
        .o_d   (w_side2)
    );

    // clamp a negative angle to zero, then scale by 1-t and t
    assign w_theta = w_vec_z[ANG_W-1] ? '0 : w_vec_z[AD_W-1:0];
    assign w_t2    = w_side2[OFS_T +: T_W];
    assign n_m1    = (AD_W+T_W)'(w_theta) * (AD_W+T_W)'(T_ONE - w_t2);
    assign n_m2    = (AD_W+T_W)'(w_theta) * (AD_W+T_W)'(w_t2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_valid <= 1'b0;
        end else if (w_en) begin
            r_ang_valid <= w_vec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_theta <= w_theta;
            r_ang1  <= n_m1[AD_W+15:16];
            r_ang2  <= n_m2[AD_W+15:16];
            r_side2 <= w_side2;
        end
    end

    qs_cordic #(.NI(NI), .VECTOR(1'b0)) u_sin_den (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_ang_valid),
        .i_x     (ANG_W'(ONE_Q30)),
        .i_y     ('0),
        .i_z     (ANG_W'(r_theta)),
        .o_valid (w_den_valid),
        .o_x     (w_d_x),
        .o_y     (w_den),
        .o_z     (w_d_z)
    );

    qs_cordic #(.NI(NI), .VECTOR(1'b0)) u_sin_num1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_ang_valid),
        .i_x     (ANG_W'(ONE_Q30)),
        .i_y     ('0),
        .i_z     (ANG_W'(r_ang1)),
        .o_valid (w_num1_valid),
        .o_x     (w_n1_x),
        .o_y     (w_num1),
        .o_z     (w_n1_z)
    );

    qs_cordic #(.NI(NI), .VECTOR(1'b0)) u_sin_num2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_ang_valid),
        .i_x     (ANG_W'(ONE_Q30)),
        .i_y     ('0),
        .i_z     (ANG_W'(r_ang2)),
        .o_valid (w_num2_valid),
        .o_x     (w_n2_x),
        .o_y     (w_num2),
        .o_z     (w_n2_z)
    );

    qs_delay #(.W(SIDE_W), .DEPTH(NI + DIV_LAT)) u_dly_weight (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_side2),
        .o_d   (w_side3)
    );

    qs_div u_div1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_num1_valid && w_den_valid),
        .i_num     (w_num1),
        .i_den     (w_den),
        .o_valid   (w_div1_valid),
        .o_q       (w_q1),
        .o_den_pos (w_den_pos)
    );

    qs_div u_div2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_num2_valid),
        .i_num     (w_num2),
        .i_den     (w_den),
        .o_valid   (w_div2_valid),
        .o_q       (w_q2),
        .o_den_pos (w_unused_pos)
    );

    qs_combine #(.CW(CW)) u_combine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_div1_valid && w_div2_valid),
        .i_q1      (w_q1),
        .i_q2      (w_q2),
        .i_den_pos (w_den_pos),
        .i_side    (w_side3),
        .o_valid   (w_comb_valid),
        .o_r       (w_comb_r)
    );

    // output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_out.ready) begin
                r_out_r      <= r_skid_r;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= w_comb_valid;
            r_out_r     <= w_comb_r;
        end else if (w_comb_valid) begin
            r_skid_r     <= w_comb_r;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.r_w   = r_out_r[0];
    assign o_out.r_x   = r_out_r[1];
    assign o_out.r_y   = r_out_r[2];
    assign o_out.r_z   = r_out_r[3];

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_out.ready) |=> r_skid_valid)
        else $error("skid dropped a result that was not transferred");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_comb_valid && !r_skid_valid && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("finished result lost during an output stall");

    a_thr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && paddr[2] == REG_LINEAR_THRESHOLD)
            |=> r_thr == $past(pwdata[THR_W-1:0]))
        else $error("threshold write not taken");
endmodule

// File: hw/rtl/qs_delay.sv
module qs_delay import qs_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_d = r_q[DEPTH-1];
endmodule

// File: hw/rtl/qs_front.sv
module qs_front import qs_pkg::*; #(
    parameter int CW = CW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [CW-1:0]       i_a [4],
    input  logic signed [CW-1:0]       i_b [4],
    input  logic [T_W-1:0]             i_fraction,
    input  logic                       i_flip,
    input  logic [THR_W-1:0]           i_thr,
    output logic                       o_valid,
    output logic [REM_W-1:0]           o_rem,
    output logic [8*CW+SIDE_FIX_W-1:0] o_side
);
    localparam int F      = CW - 2;
    localparam int PRE    = (CW > 30) ? 2 : 0;
    localparam int SH     = 2 * F - PRE - Q;
    localparam int PW     = 2 * CW;
    localparam int SW     = 2 * CW - PRE + 2;
    localparam int BASE_W = 8 * CW + T_W + 1;

    logic [4:0]              r_vld;
    logic [BASE_W-1:0]       r1_base, r2_base, r3_base, r4_base;
    logic signed [PW-1:0]    r2_p [4];
    logic signed [DOT_W-1:0] r3_dot;
    logic [AD_W-1:0]         r4_ad;
    logic                    r4_lin, r4_neg;
    logic [REM_W-1:0]        r5_rem;
    logic [8*CW+SIDE_FIX_W-1:0] r5_side;

    logic signed [CW-1:0]    w_a [4];
    logic signed [CW-1:0]    w_b [4];
    logic signed [SW-1:0]    n_sum;
    logic signed [DOT_W-1:0] n_dot;
    logic signed [DOT_W-1:0] n_ad;
    logic signed [DOT_W:0]   n_diff;
    logic [REM_W-1:0]        n_sq;

    for (genvar k = 0; k < 4; k++) begin : g_unpack
        assign w_a[k] = r1_base[T_W + 1 + (7 - k) * CW +: CW];
        assign w_b[k] = r1_base[T_W + 1 + (3 - k) * CW +: CW];
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < 4; k++) begin
            n_sum = n_sum + SW'(r2_p[k] >>> PRE);
        end
    end

    if (SH >= 0) begin : g_shr
        assign n_dot = DOT_W'(n_sum >>> SH);
    end else begin : g_shl
        assign n_dot = DOT_W'(n_sum) <<< (-SH);
    end

    assign n_ad   = r3_dot[DOT_W-1] ? -r3_dot : r3_dot;
    assign n_diff = (DOT_W+1)'(ONE_Q30) - (DOT_W+1)'(n_ad);
    assign n_sq   = REM_W'(r4_ad) * REM_W'(r4_ad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_base <= {i_a[0], i_a[1], i_a[2], i_a[3], i_b[0], i_b[1], i_b[2], i_b[3],
                        (i_fraction > T_ONE) ? T_ONE : i_fraction, i_flip};
            for (int k = 0; k < 4; k++) begin
                r2_p[k] <= PW'(w_a[k]) * PW'(w_b[k]);
            end
            r2_base <= r1_base;
            r3_dot  <= n_dot;
            r3_base <= r2_base;
            r4_ad   <= n_ad[AD_W-1:0];
            r4_neg  <= r3_dot[DOT_W-1];
            // linear when 1 - |d| falls below the margin
            r4_lin  <= n_diff < $signed((DOT_W+1)'({i_thr, 16'b0}));
            r4_base <= r3_base;
            r5_rem  <= (REM_W'(1) << (2 * Q)) - n_sq;
            r5_side <= {r4_base, r4_neg, r4_lin, r4_ad};
        end
    end

    assign o_valid = r_vld[4];
    assign o_rem   = r5_rem;
    assign o_side  = r5_side;
endmodule

// File: hw/rtl/qs_isqrt.sv
module qs_isqrt import qs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [REM_W-1:0] i_rem,
    output logic             o_valid,
    output logic [AD_W-1:0]  o_root
);
    logic [REM_W-1:0]      r_v   [SQRT_STEPS];
    logic [REM_W-1:0]      r_res [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] r_vld;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        localparam int BITPOS = 2 * (SQRT_STEPS - 1 - g);
        logic [REM_W-1:0] w_v, w_res, w_sum;

        if (g == 0) begin : g_first
            assign w_v   = i_rem;
            assign w_res = '0;
        end else begin : g_next
            assign w_v   = r_v[g-1];
            assign w_res = r_res[g-1];
        end

        assign w_sum = w_res + (REM_W'(1) << BITPOS);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_v >= w_sum) begin
                    r_v[g]   <= w_v - w_sum;
                    r_res[g] <= (w_res >> 1) + (REM_W'(1) << BITPOS);
                end else begin
                    r_v[g]   <= w_v;
                    r_res[g] <= w_res >> 1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_STEPS-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_root  = r_res[SQRT_STEPS-1][AD_W-1:0];
endmodule

// File: hw/rtl/qs_cordic.sv
module qs_cordic import qs_pkg::*; #(
    parameter int NI     = NI_DEF,
    parameter bit VECTOR = 1'b0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [ANG_W-1:0] i_x,
    input  logic signed [ANG_W-1:0] i_y,
    input  logic signed [ANG_W-1:0] i_z,
    output logic                    o_valid,
    output logic signed [ANG_W-1:0] o_x,
    output logic signed [ANG_W-1:0] o_y,
    output logic signed [ANG_W-1:0] o_z
);
    logic signed [ANG_W-1:0] r_x [NI];
    logic signed [ANG_W-1:0] r_y [NI];
    logic signed [ANG_W-1:0] r_z [NI];
    logic [NI-1:0]           r_vld;

    for (genvar g = 0; g < NI; g++) begin : g_step
        logic signed [ANG_W-1:0] w_x, w_y, w_z;
        logic                    w_ccw;

        if (g == 0) begin : g_first
            assign w_x = i_x;
            assign w_y = i_y;
            assign w_z = i_z;
        end else begin : g_next
            assign w_x = r_x[g-1];
            assign w_y = r_y[g-1];
            assign w_z = r_z[g-1];
        end

        // vectoring drives y to zero, rotation drives z to zero
        assign w_ccw = VECTOR ? w_y[ANG_W-1] : !w_z[ANG_W-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_ccw) begin
                    r_x[g] <= w_x - (w_y >>> g);
                    r_y[g] <= w_y + (w_x >>> g);
                    r_z[g] <= w_z - atan_q30(g);
                end else begin
                    r_x[g] <= w_x + (w_y >>> g);
                    r_y[g] <= w_y - (w_x >>> g);
                    r_z[g] <= w_z + atan_q30(g);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NI-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[NI-1];
    assign o_x     = r_x[NI-1];
    assign o_y     = r_y[NI-1];
    assign o_z     = r_z[NI-1];
endmodule

// File: hw/rtl/qs_div.sv
module qs_div import qs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [ANG_W-1:0] i_num,
    input  logic signed [ANG_W-1:0] i_den,
    output logic                    o_valid,
    output logic [AD_W-1:0]         o_q,
    output logic                    o_den_pos
);
    logic [RW-1:0]        r_rem  [DIV_STEPS+1];
    logic [RW-1:0]        r_den  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q    [DIV_STEPS+1];
    logic                 r_sat  [DIV_STEPS+1];
    logic                 r_dpos [DIV_STEPS+1];
    logic [DIV_STEPS:0]   r_vld;

    logic n_den_pos, n_num_pos, n_sat;

    assign n_den_pos = !i_den[ANG_W-1] && (i_den != '0);
    assign n_num_pos = !i_num[ANG_W-1] && (i_num != '0);
    // quotient of at least one clamps to 1.0
    assign n_sat     = n_num_pos && n_den_pos && (i_num >= i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= (n_num_pos && n_den_pos && !n_sat) ? RW'(i_num) : '0;
            r_den[0]  <= RW'(i_den);
            r_q[0]    <= '0;
            r_sat[0]  <= n_sat;
            r_dpos[0] <= n_den_pos;
        end
    end

    for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
        logic [RW-1:0] w_r2;
        logic          w_bit;

        assign w_r2  = {r_rem[g-1][RW-2:0], 1'b0};
        assign w_bit = w_r2 >= r_den[g-1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_bit ? w_r2 - r_den[g-1] : w_r2;
                r_den[g]  <= r_den[g-1];
                r_q[g]    <= {r_q[g-1][DIV_STEPS-2:0], w_bit};
                r_sat[g]  <= r_sat[g-1];
                r_dpos[g] <= r_dpos[g-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_valid};
        end
    end

    assign o_valid   = r_vld[DIV_STEPS];
    assign o_q       = r_sat[DIV_STEPS] ? AD_W'(ONE_Q30) : AD_W'(r_q[DIV_STEPS]);
    assign o_den_pos = r_dpos[DIV_STEPS];
endmodule

// File: hw/rtl/qs_combine.sv
module qs_combine import qs_pkg::*; #(
    parameter int CW = CW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [AD_W-1:0]            i_q1,
    input  logic [AD_W-1:0]            i_q2,
    input  logic                       i_den_pos,
    input  logic [8*CW+SIDE_FIX_W-1:0] i_side,
    output logic                       o_valid,
    output logic signed [CW-1:0]       o_r [4]
);
    localparam int PW = WT_W + CW;
    localparam logic signed [PW:0] HI = (PW+1)'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [PW:0] LO = -HI - (PW+1)'(1);

    logic [1:0]           r_vld;
    logic signed [PW-1:0] r_p1 [4];
    logic signed [PW-1:0] r_p2 [4];
    logic signed [CW-1:0] r_r  [4];

    logic signed [CW-1:0]   w_a [4];
    logic signed [CW-1:0]   w_b [4];
    logic [T_W-1:0]         w_t;
    logic                   w_use_lin;
    logic signed [WT_W-1:0] n_c1, n_c2;

    for (genvar k = 0; k < 4; k++) begin : g_unpack
        assign w_a[k] = i_side[SIDE_FIX_W + (7 - k) * CW +: CW];
        assign w_b[k] = i_side[SIDE_FIX_W + (3 - k) * CW +: CW];
    end

    assign w_t       = i_side[OFS_T +: T_W];
    assign w_use_lin = i_side[OFS_LIN] || !i_den_pos;

    always_comb begin
        if (w_use_lin) begin
            n_c1 = WT_W'({T_ONE - w_t, 14'b0});
            n_c2 = WT_W'({w_t, 14'b0});
        end else begin
            n_c1 = WT_W'(i_q1);
            n_c2 = WT_W'(i_q2);
        end
        if (i_side[OFS_FLIP] && i_side[OFS_NEG]) begin
            n_c1 = -n_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic signed [PW:0] n_sum, n_sh;

        assign n_sum = (PW+1)'(r_p1[k]) + (PW+1)'(r_p2[k]) + (PW+1)'(ONE_Q30 >>> 1);
        assign n_sh  = n_sum >>> Q;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p1[k] <= PW'(n_c1) * PW'(w_a[k]);
                r_p2[k] <= PW'(n_c2) * PW'(w_b[k]);
                if (n_sh > HI) begin
                    r_r[k] <= HI[CW-1:0];
                end else if (n_sh < LO) begin
                    r_r[k] <= LO[CW-1:0];
                end else begin
                    r_r[k] <= n_sh[CW-1:0];
                end
            end
        end

        assign o_r[k] = r_r[k];
    end

    assign o_valid = r_vld[1];
endmodule

// File: tb/tb_quaternion_slerp_top.sv
module tb_quaternion_slerp_top;
    import qs_pkg::*;

    localparam int CW        = 16;
    localparam int NITER     = 16;
    localparam int LATENCY   = 71 + 2 * NITER;
    localparam int MAX_CYCLES = 400000;
    localparam logic [2:0] ADDR_LINEAR_THRESHOLD = 3'd0;

    typedef struct {
        logic signed [CW-1:0] a [4];
        logic signed [CW-1:0] b [4];
        logic [T_W-1:0]       fraction;
        logic                 allow_flip;
    } slerp_req_t;

    typedef struct {
        logic signed [CW-1:0] r [4];
    } slerp_quat_t;

    // Arithmetic shift right, rounding toward minus infinity.
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint res, bit_v;
        res = 0;
        bit_v = 64'sd1 <<< 62;
        while (bit_v > v) bit_v = bit_v >>> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v = v - (res + bit_v);
                res = (res >>> 1) + bit_v;
            end else begin
                res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    function automatic longint arctan_step(int i);
        longint tbl [16];
        tbl = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                131071, 65535, 32767};
        return tbl[i];
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < NITER; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_step(i);
            end else begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint rotate_sine(longint z);
        longint x, y, dx, dy;
        x = 64'sd1 <<< 30;
        y = 0;
        for (int i = 0; i < NITER; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        return y;
    endfunction

    function automatic longint clamp_weight(longint num, longint den);
        longint q;
        q = (num * (64'sd1 <<< 30)) / den;
        if (q < 0) q = 0;
        if (q > (64'sd1 <<< 30)) q = 64'sd1 <<< 30;
        return q;
    endfunction

    function automatic slerp_quat_t interpolate(slerp_req_t req, logic [THR_W-1:0] margin);
        slerp_quat_t res;
        longint dot, ad, t, w1, w2, s, theta, den, acc;
        dot = 0;
        for (int i = 0; i < 4; i++) dot += longint'(req.a[i]) * longint'(req.b[i]);
        dot = dot <<< 2;
        ad = dot < 0 ? -dot : dot;
        t = req.fraction;
        if (t > 65536) t = 65536;
        w1 = (65536 - t) * 16384;
        w2 = t * 16384;
        if ((64'sd1 <<< 30) - ad >= longint'(margin) * 65536) begin
            s = floor_sqrt((64'sd1 <<< 60) - ad * ad);
            theta = vector_angle(ad, s);
            if (theta < 0) theta = 0;
            den = rotate_sine(theta);
            if (den > 0) begin
                w1 = clamp_weight(rotate_sine((theta * (65536 - t)) >>> 16), den);
                w2 = clamp_weight(rotate_sine((theta * t) >>> 16), den);
            end
        end
        if (req.allow_flip && dot < 0) w1 = -w1;
        for (int i = 0; i < 4; i++) begin
            acc = shr_floor(w1 * req.a[i] + w2 * req.b[i] + (64'sd1 <<< 29), 30);
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            res.r[i] = acc[CW-1:0];
        end
        return res;
    endfunction

    class slerp_scoreboard;
        slerp_quat_t pending[$];
        logic [THR_W-1:0] margin;
        int errors;

        function new();
            margin = THR_RESET;
            errors = 0;
        endfunction

        function void note_request(slerp_req_t req);
            pending.push_back(interpolate(req, margin));
        endfunction

        function void check_result(slerp_quat_t got);
            slerp_quat_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %0d %0d %0d %0d", $time,
                         got.r[0], got.r[1], got.r[2], got.r[3]);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 4; i++)
                if (got.r[i] !== want.r[i]) begin
                    $display("%0t: component %0d expected %0d actual %0d", $time, i,
                             want.r[i], got.r[i]);
                    errors++;
                end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    qs_in_if  #(.CW(CW)) in_ch ();
    qs_out_if #(.CW(CW)) out_ch ();

    quaternion_slerp_top #(.COMPONENT_WIDTH(CW), .CORDIC_ITERATIONS(NITER)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    slerp_scoreboard sb = new();
    bit calm_phase = 1'b0;
    longint cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.a_w = '0; in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
        in_ch.b_w = '0; in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
        in_ch.fraction = '0;
        in_ch.allow_flip = 1'b0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sample result transfers at the rising edge; the next stall is drawn at the falling edge.
    always @(posedge i_clk) begin
        slerp_quat_t got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.r[0] = out_ch.r_w; got.r[1] = out_ch.r_x;
            got.r[2] = out_ch.r_y; got.r[3] = out_ch.r_z;
            sb.check_result(got);
        end
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_margin(logic [THR_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_LINEAR_THRESHOLD;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.margin = value;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_request(slerp_req_t req);
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.a_w <= req.a[0]; in_ch.a_x <= req.a[1];
        in_ch.a_y <= req.a[2]; in_ch.a_z <= req.a[3];
        in_ch.b_w <= req.b[0]; in_ch.b_x <= req.b[1];
        in_ch.b_y <= req.b[2]; in_ch.b_z <= req.b[3];
        in_ch.fraction <= req.fraction;
        in_ch.allow_flip <= req.allow_flip;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Unit-ish quaternion near a reference, so dots cluster close to one.
    function automatic slerp_req_t rand_request();
        slerp_req_t req;
        int spread;
        spread = 1 << $urandom_range(0, 14);
        for (int i = 0; i < 4; i++) req.a[i] = rand_comp();
        for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 3) == 0) req.b[i] = rand_comp();
            else req.b[i] = 16'(int'(req.a[i]) + $urandom_range(0, 2 * spread) - spread);
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 4; i++) req.b[i] = -req.b[i];
        case ($urandom_range(0, 7))
            0: req.fraction = 17'd0;
            1: req.fraction = T_ONE;
            2: req.fraction = 17'($urandom);
            default: req.fraction = 17'($urandom_range(0, 65536));
        endcase
        req.allow_flip = 1'($urandom);
        return req;
    endfunction

    function automatic slerp_req_t make_req(int aw, int ax, int ay, int az, int bw, int bx,
                                            int by, int bz, int t, bit flip);
        slerp_req_t req;
        req.a = '{16'(aw), 16'(ax), 16'(ay), 16'(az)};
        req.b = '{16'(bw), 16'(bx), 16'(by), 16'(bz)};
        req.fraction = 17'(t);
        req.allow_flip = flip;
        return req;
    endfunction

    initial begin
        slerp_req_t dir [$];
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        dir.push_back(make_req(16384, 0, 0, 0, 16384, 0, 0, 0, 32768, 0));
        dir.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0));
        dir.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 65536, 0));
        dir.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 21845, 1));
        dir.push_back(make_req(16384, 0, 0, 0, 11585, 11585, 0, 0, 131071, 0));
        dir.push_back(make_req(16384, 0, 0, 0, -11585, 11585, 0, 0, 40000, 1));
        dir.push_back(make_req(16384, 0, 0, 0, -11585, 11585, 0, 0, 40000, 0));
        dir.push_back(make_req(16384, 0, 0, 0, -16384, 0, 0, 0, 32768, 1));
        dir.push_back(make_req(16384, 0, 0, 0, -16384, 0, 0, 0, 32768, 0));
        dir.push_back(make_req(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
                               30000, 0));
        dir.push_back(make_req(-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767,
                               65536, 1));
        dir.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                               100000, 0));
        dir.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 12345, 1));
        dir.push_back(make_req(16384, 0, 0, 0, 16300, 1600, 0, 0, 32768, 0));
        dir.push_back(make_req(16384, 0, 0, 0, 16383, 200, 0, 0, 50000, 1));
        dir.push_back(make_req(16384, 0, 0, 0, 16, 16384, 0, 0, 1, 0));
        dir.push_back(make_req(-16384, 16384, -16384, 16384, 16384, -16384, 16384, -16384,
                               65535, 1));
        foreach (dir[i]) send_request(dir[i]);

        // Pause the sender until the pipe drains completely.
        go_idle();
        write_margin(15'd0);
        for (int i = 0; i < 100; i++) send_request(rand_request());
        go_idle();
        write_margin(15'h7FFF);
        for (int i = 0; i < 50; i++) send_request(rand_request());
        go_idle();
        write_margin(15'd16384);
        for (int i = 0; i < 50; i++) send_request(rand_request());
        go_idle();
        write_margin(15'($urandom_range(1, 2000)));
        for (int i = 0; i < 150; i++) send_request(rand_request());
        go_idle();
        write_margin(THR_RESET);
        calm_phase = 1'b1;
        for (int i = 0; i < 100; i++) send_request(rand_request());
        go_idle();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: quaternion_slerp_top.f
hw/rtl/qs_pkg.sv
hw/rtl/qs_in_if.sv
hw/rtl/qs_out_if.sv
hw/rtl/qs_delay.sv
hw/rtl/qs_front.sv
hw/rtl/qs_isqrt.sv
hw/rtl/qs_cordic.sv
hw/rtl/qs_div.sv
hw/rtl/qs_combine.sv
hw/rtl/quaternion_slerp_top.sv
tb/tb_quaternion_slerp_top.sv
